### sv/cmi_pkg.sv
// Shared types, codes and constants of the colour map interpolator.
`default_nettype none
package cmi_pkg;

  localparam int DEFAULT_MAX_BREAKPOINTS = 128;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [15:0] GREY_LEVEL = 16'd32767;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
  } entry_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

endpackage
`default_nettype wire

### sv/cmi_front.sv
// Input stage: accepts transfers and classifies the operation into a command.
`default_nettype none
module cmi_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [79:0]   s_axis_tdata,  // sample_value, in_red, in_green, in_blue
  input  wire logic [1:0]    s_axis_tuser,  // operation
  output cmi_pkg::push_t     push,
  input  wire logic          push_ready
);
  import cmi_pkg::*;

  logic full;
  cmd_t cmd;
  logic [1:0] kind;

  always_comb begin
    case (s_axis_tuser)
      OP_CLEAR:  kind = KIND_CLEAR;
      OP_INSERT: kind = KIND_INSERT;
      OP_LOOKUP: kind = KIND_LOOKUP;
      default:   kind = KIND_NOP;
    endcase
  end

  assign s_axis_tready = !full || push_ready;
  assign push.valid = full;
  assign push.cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_axis_tready) begin
      full <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      cmd.kind  <= kind;
      cmd.value <= s_axis_tdata[31:0];
      cmd.red   <= s_axis_tdata[47:32];
      cmd.green <= s_axis_tdata[63:48];
      cmd.blue  <= s_axis_tdata[79:64];
    end
  end

endmodule
`default_nettype wire

### sv/cmi_queue.sv
// Command queue between the input stage and the table engine.
`default_nettype none
module cmi_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cmi_pkg::push_t push,
  output logic               push_ready,
  output logic               pop_valid,
  input  wire logic          pop,
  output cmi_pkg::cmd_t      pop_cmd
);
  import cmi_pkg::*;

  cmd_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic do_push;
  logic do_pop;

  assign push_ready = (fill != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_cmd = mem[rd_ptr];
  assign do_push = push.valid && push_ready;
  assign do_pop = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (!do_push && do_pop) fill <= fill - 1'b1;
    end
    if (do_push) mem[wr_ptr] <= push.cmd;
  end

endmodule
`default_nettype wire

### sv/cmi_engine.sv
// Table engine: sorted breakpoint memory, insert shifter, interval search and blend divider.
`default_nettype none
module cmi_engine #(
  parameter int MAX_BREAKPOINTS = cmi_pkg::DEFAULT_MAX_BREAKPOINTS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_pop,
  input  wire cmi_pkg::cmd_t cmd,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [63:0]        m_axis_tdata  // out_red, out_green, out_blue, status, entry_total
);
  import cmi_pkg::*;

  localparam int AW = $clog2(MAX_BREAKPOINTS);
  localparam int CW = $clog2(MAX_BREAKPOINTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ICHK = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SWR  = 4'd3;
  localparam logic [3:0] S_L0   = 4'd4;
  localparam logic [3:0] S_L1   = 4'd5;
  localparam logic [3:0] S_LCHK = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  entry_t mem [MAX_BREAKPOINTS];
  entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic we;
  logic [AW-1:0] wa;
  entry_t wd;

  logic [3:0] state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  cmd_t cmd_r;
  entry_t lo;
  entry_t hi;
  logic [32:0] len;
  logic [32:0] delta;
  logic [32:0] rest;
  logic [1:0] ch;
  logic [48:0] prod;
  logic [32:0] rem;
  logic [15:0] quo;
  logic [3:0] bitcnt;
  logic [15:0] red_r;
  logic [15:0] green_r;
  logic [15:0] blue_r;
  logic [1:0] status_r;

  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] last;
  logic [CW+7:0] count_ext;
  logic [15:0] c_lo;
  logic [15:0] c_hi;
  logic [48:0] prod_next;
  logic [32:0] rem_src;
  logic [33:0] trial;
  logic ge;
  logic [32:0] rem_next;
  logic [15:0] quo_next;
  logic [32:0] x_ext;
  logic [32:0] lo_ext;
  logic [32:0] hi_ext;

  assign idx_inc = idx + 1'b1;
  assign idx_dec = idx - 1'b1;
  assign last = count - 1'b1;
  assign count_ext = {8'b0, count};
  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  assign x_ext = {cmd_r.value[31], cmd_r.value};
  assign lo_ext = {lo.value[31], lo.value};
  assign hi_ext = {rd_data.value[31], rd_data.value};

  always_comb begin
    case (ch)
      2'd0: begin c_lo = lo.red;   c_hi = hi.red; end
      2'd1: begin c_lo = lo.green; c_hi = hi.green; end
      default: begin c_lo = lo.blue; c_hi = hi.blue; end
    endcase
  end

  assign prod_next = 49'(c_lo) * 49'(rest) + 49'(c_hi) * 49'(delta);
  assign rem_src = (bitcnt == 4'd0) ? prod[48:16] : rem;
  assign trial = {rem_src, prod[15]};
  assign ge = (trial >= {1'b0, len});
  assign rem_next = ge ? 33'(trial - {1'b0, len}) : trial[32:0];
  assign quo_next = {quo[14:0], ge};

  always_comb begin
    rd_addr = '0;
    we = 1'b0;
    wa = idx[AW-1:0];
    wd = rd_data;
    case (state)
      S_ICHK, S_LCHK: rd_addr = idx_inc[AW-1:0];
      S_L0: rd_addr = last[AW-1:0];
      S_L1: rd_addr = AW'(1);
      S_SRD: begin
        rd_addr = idx_dec[AW-1:0];
        if (idx == pos) begin
          we = 1'b1;
          wa = pos[AW-1:0];
          wd = '{value: cmd_r.value, red: cmd_r.red, green: cmd_r.green, blue: cmd_r.blue};
        end
      end
      S_SWR: we = 1'b1;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            idx <= '0;
            case (cmd.kind)
              KIND_CLEAR: begin
                count <= '0;
                {red_r, green_r, blue_r} <= '0;
                status_r <= STATUS_OK;
                state <= S_DONE;
              end
              KIND_INSERT: begin
                {red_r, green_r, blue_r} <= '0;
                if (count == CW'(MAX_BREAKPOINTS)) begin
                  status_r <= STATUS_FULL;
                  state <= S_DONE;
                end else begin
                  status_r <= STATUS_OK;
                  state <= S_ICHK;
                end
              end
              KIND_LOOKUP: begin
                if (count == '0) begin
                  {red_r, green_r, blue_r} <= {3{GREY_LEVEL}};
                  status_r <= STATUS_EMPTY;
                  state <= S_DONE;
                end else begin
                  {red_r, green_r, blue_r} <= '0;
                  status_r <= STATUS_OK;
                  state <= S_L0;
                end
              end
              default: begin
                {red_r, green_r, blue_r} <= '0;
                status_r <= STATUS_OK;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_ICHK: begin
          if (idx == count || $signed(rd_data.value) > $signed(cmd_r.value)) begin
            pos <= idx;
            idx <= count;
            state <= S_SRD;
          end else begin
            idx <= idx_inc;
          end
        end
        S_SRD: begin
          if (idx == pos) begin
            count <= count + 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_SWR;
          end
        end
        S_SWR: begin
          idx <= idx_dec;
          state <= S_SRD;
        end
        S_L0: begin
          lo <= rd_data;
          if ($signed(cmd_r.value) <= $signed(rd_data.value)) begin
            red_r <= rd_data.red;
            green_r <= rd_data.green;
            blue_r <= rd_data.blue;
            state <= S_DONE;
          end else begin
            state <= S_L1;
          end
        end
        S_L1: begin
          idx <= CW'(1);
          if ($signed(cmd_r.value) >= $signed(rd_data.value)) begin
            red_r <= rd_data.red;
            green_r <= rd_data.green;
            blue_r <= rd_data.blue;
            state <= S_DONE;
          end else begin
            state <= S_LCHK;
          end
        end
        S_LCHK: begin
          if ($signed(rd_data.value) >= $signed(cmd_r.value)) begin
            hi <= rd_data;
            len <= hi_ext - lo_ext;
            delta <= x_ext - lo_ext;
            rest <= hi_ext - x_ext;
            ch <= 2'd0;
            state <= S_MUL;
          end else begin
            lo <= rd_data;
            idx <= idx_inc;
          end
        end
        S_MUL: begin
          prod <= prod_next;
          bitcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          prod <= {prod[47:0], 1'b0};
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == 4'd15) begin
            case (ch)
              2'd0: red_r <= quo_next;
              2'd1: green_r <= quo_next;
              default: blue_r <= quo_next;
            endcase
            ch <= ch + 1'b1;
            state <= (ch == 2'd2) ? S_DONE : S_MUL;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {6'b0, count_ext[7:0], status_r, blue_r, green_r, red_r};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/colormap_interpolator.sv
// Top level of the piecewise-linear colour map interpolator.
//
//  channel  direction  handshake                      payload
//  s_axis   in         s_axis_tvalid / s_axis_tready  tdata 80 b, tuser 2 b
//  m_axis   out        m_axis_tvalid / m_axis_tready  tdata 64 b
//
// Clear, unused codes, full insert and empty lookup go from idle straight to the done state.
// Insert scans one entry a cycle up to its slot p, then shifts the n - p entries
// above it up one place, each by a read state and a write state.
// Lookup at or beyond the ends returns that end entry's colour; inside, it scans to
// the upper entry j of the interval and blends each colour with a 16-step divider.
// Reset empties the table at once. The command queue keeps input transfers
// flowing while the engine works; a held result stalls the engine.
`default_nettype none
module colormap_interpolator #(
  parameter int MAX_BREAKPOINTS = cmi_pkg::DEFAULT_MAX_BREAKPOINTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // sample_value, in_red, in_green, in_blue
  input  wire logic [1:0]  s_axis_tuser,  // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata   // out_red, out_green, out_blue, status, entry_total
);
  import cmi_pkg::*;

  push_t push;
  logic push_ready;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  cmi_front u_front (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .push(push),
    .push_ready(push_ready)
  );

  cmi_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_ready(push_ready),
    .pop_valid(cmd_valid),
    .pop(cmd_pop),
    .pop_cmd(cmd)
  );

  cmi_engine #(
    .MAX_BREAKPOINTS(MAX_BREAKPOINTS)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_pop(cmd_pop),
    .cmd(cmd),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

endmodule
`default_nettype wire
